[hw/rtl/oaht_pkg.sv]
// Package for the open address hash table: sizes, status codes, slot states.
// No dependencies.
package oaht_pkg;
   localparam int TableSlotsDef = 101;
   localparam int ProbeLimitDef = 20;
   localparam int KeyBytesDef   = 15;

   localparam logic [1:0] MODE_ADD   = 2'd0;
   localparam logic [1:0] MODE_DEL   = 2'd1;
   localparam logic [1:0] MODE_READ  = 2'd2;
   localparam logic [1:0] MODE_CLEAR = 2'd3;

   localparam logic [2:0] ST_INSERTED = 3'd0;
   localparam logic [2:0] ST_PRESENT  = 3'd1;
   localparam logic [2:0] ST_FULL     = 3'd2;
   localparam logic [2:0] ST_DELETED  = 3'd3;
   localparam logic [2:0] ST_MISSING  = 3'd4;
   localparam logic [2:0] ST_READ     = 3'd5;
   localparam logic [2:0] ST_CLEARED  = 3'd6;

   localparam logic [1:0] SLOT_NEVER = 2'd0;
   localparam logic [1:0] SLOT_LIVE  = 2'd1;
   localparam logic [1:0] SLOT_DEAD  = 2'd2;
endpackage

[hw/rtl/open_address_hash_table.sv]
// Open address hash table top level: sequencer, slot memories, shared hash/probe unit.
// Depends on oaht_pkg.
//
//  channel | dir | ports                                         | beat
//  req     | in  | req_valid req_stall req_mode req_key_* req_slot_sel | one op
//  rsp     | out | rsp_valid rsp_stall rsp_status .. rsp_live_count   | one result
//
// An add or delete hashes one key byte a cycle, then scales the sum, forms the
// residue by a reciprocal multiply and a subtract, and probes the one-port slot
// memory by issuing an address and checking the registered read; an add of a new
// key makes a second probe pass and a write step. A read addresses its slot
// and takes its registered read; a clear sweeps all TABLE_SLOTS slots.
// After reset a clearing pass over all TABLE_SLOTS slots runs before any request.
// req_stall is high while an item is in work; a result held by rsp_stall sits in the
// output register, and the next item waits in its output step only if it is still held.
module open_address_hash_table
   import oaht_pkg::*;
#(
   localparam int TABLE_SLOTS = TableSlotsDef,
   parameter int PROBE_LIMIT = ProbeLimitDef,
   parameter int KEY_BYTES   = KeyBytesDef
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_mode,
   input  logic [63:0] req_key_lo,
   input  logic [55:0] req_key_hi,
   input  logic [3:0]  req_key_len,
   input  logic [6:0]  req_slot_sel,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_status,
   output logic [6:0]  rsp_slot,
   output logic        rsp_occupied,
   output logic [63:0] rsp_out_key_lo,
   output logic [55:0] rsp_out_key_hi,
   output logic [3:0]  rsp_out_key_len,
   output logic [6:0]  rsp_live_count
);
   localparam int SW = $clog2(TABLE_SLOTS);
   localparam int AW = $clog2(TABLE_SLOTS + 1);
   localparam int JW = $clog2(PROBE_LIMIT + 1);
   localparam int BW = $clog2(KEY_BYTES + 1);
   // hash sum: at most 255*15*16/2*19 = 581400, fits in 20 bits
   localparam int HW = 20;
   // floor(x / TABLE_SLOTS) = (x * RECIP) >> RSH, exact for any x below 2^20
   localparam int RSH = 31;
   localparam longint unsigned RECIP = ((64'd1 << RSH) + TABLE_SLOTS - 1) / TABLE_SLOTS;

   localparam logic [3:0] S_INIT  = 4'd0;
   localparam logic [3:0] S_IDLE  = 4'd1;
   localparam logic [3:0] S_HASH  = 4'd2;
   localparam logic [3:0] S_MOD   = 4'd3;
   localparam logic [3:0] S_ADDR  = 4'd4;
   localparam logic [3:0] S_CHECK = 4'd5;
   localparam logic [3:0] S_WRITE = 4'd6;
   localparam logic [3:0] S_RDA   = 4'd7;
   localparam logic [3:0] S_RDB   = 4'd8;
   localparam logic [3:0] S_CLEAR = 4'd9;
   localparam logic [3:0] S_OUT   = 4'd10;
   localparam logic [3:0] S_REM   = 4'd11;

   logic [3:0]    state_ff, state_in;
   logic [1:0]    mode_ff, mode_in;
   logic [63:0]   lo_ff, lo_in;
   logic [55:0]   hi_ff, hi_in;
   logic [3:0]    len_ff, len_in;
   logic [6:0]    sel_ff, sel_in;
   logic [HW-1:0] acc_ff, acc_in;
   logic [HW-1:0] quo_ff, quo_in;
   logic [BW-1:0] bi_ff, bi_in;
   logic [SW-1:0] pos_ff, pos_in;     // current probe slot, also clear sweep index
   logic [SW-1:0] step_ff, step_in;   // increment to next probe: (2j+24) mod N
   logic [JW-1:0] j_ff, j_in;
   logic          pass_ff, pass_in;   // 0 lookup, 1 free search
   logic [6:0]    live_ff, live_in;
   logic          rv_ff, rv_in;
   logic [2:0]    rst_ff, rst_in;
   logic [6:0]    rslot_ff, rslot_in;
   logic          rocc_ff, rocc_in;
   logic [63:0]   rlo_ff, rlo_in;
   logic [55:0]   rhi_ff, rhi_in;
   logic [3:0]    rlen_ff, rlen_in;
   logic [2:0]    out_status_ff;
   logic [6:0]    out_slot_ff;
   logic          out_occ_ff;
   logic [63:0]   out_lo_ff;
   logic [55:0]   out_hi_ff;
   logic [3:0]    out_len_ff;
   logic [6:0]    out_live_ff;
   logic          out_load;

   logic [1:0]  stat_mem [TABLE_SLOTS];
   logic [63:0] klo_mem [TABLE_SLOTS];
   logic [55:0] khi_mem [TABLE_SLOTS];
   logic [3:0]  kln_mem [TABLE_SLOTS];
   logic [1:0]  stat_q;
   logic [63:0] klo_q;
   logic [55:0] khi_q;
   logic [3:0]  kln_q;

   logic          rd_en, st_we, key_we;
   logic [SW-1:0] rd_addr, wr_addr;
   logic [1:0]    st_wdata;

   always_ff @(posedge clock) begin
      if (st_we) stat_mem[wr_addr] <= st_wdata;
      if (key_we) begin
         klo_mem[wr_addr] <= lo_ff;
         khi_mem[wr_addr] <= hi_ff;
         kln_mem[wr_addr] <= len_ff;
      end
      if (rd_en) begin
         stat_q <= stat_mem[rd_addr];
         klo_q  <= klo_mem[rd_addr];
         khi_q  <= khi_mem[rd_addr];
         kln_q  <= kln_mem[rd_addr];
      end
   end

   logic [7:0]          byte_v;
   logic [119:0]        key_all;
   logic [SW:0]         wrap_sum;
   logic [SW:0]         step_sum;
   logic                hit;
   logic [3:0]          len_c;
   logic [63:0]         lo_mask;
   logic [55:0]         hi_mask;
   logic [HW+30:0]      prod;
   logic [HW-1:0]       hrem;

   assign key_all = {hi_ff, lo_ff};
   assign byte_v  = key_all[8*bi_ff +: 8];
   assign wrap_sum = {1'b0, pos_ff} + {1'b0, step_ff};
   assign step_sum = {1'b0, step_ff} + (SW+1)'(2);
   assign prod = (HW+31)'(acc_ff) * (HW+31)'(RECIP);
   assign hrem = acc_ff - quo_ff * HW'(TABLE_SLOTS);
   assign hit = (stat_q == SLOT_LIVE) && (kln_q == len_ff) && (klo_q == lo_ff)
                && (khi_q == hi_ff);
   assign len_c = (req_key_len > 4'(KEY_BYTES)) ? 4'(KEY_BYTES) : req_key_len;
   always_comb begin
      lo_mask = '1;
      hi_mask = '1;
      if (len_c < 4'd8) lo_mask = ~(64'hFFFF_FFFF_FFFF_FFFF << {len_c, 3'b000});
      if (len_c <= 4'd8) hi_mask = '0;
      else hi_mask = ~(56'hFF_FFFF_FFFF_FFFF << {len_c - 4'd8, 3'b000});
   end

   assign req_stall = (state_ff != S_IDLE);

   always_comb begin
      state_in = state_ff; mode_in = mode_ff; lo_in = lo_ff; hi_in = hi_ff;
      len_in = len_ff; sel_in = sel_ff; acc_in = acc_ff; bi_in = bi_ff;
      quo_in = quo_ff;
      pos_in = pos_ff; step_in = step_ff; j_in = j_ff; pass_in = pass_ff;
      live_in = live_ff; rv_in = rv_ff; rst_in = rst_ff; rslot_in = rslot_ff;
      rocc_in = rocc_ff; rlo_in = rlo_ff; rhi_in = rhi_ff; rlen_in = rlen_ff;
      rd_en = 1'b0; rd_addr = pos_ff; st_we = 1'b0; key_we = 1'b0;
      wr_addr = pos_ff; st_wdata = SLOT_NEVER; out_load = 1'b0;
      if (rv_ff && !rsp_stall) rv_in = 1'b0;
      case (state_ff)
         S_INIT, S_CLEAR: begin
            st_we = 1'b1;
            pos_in = pos_ff + 1'b1;
            if (pos_ff == SW'(TABLE_SLOTS - 1)) begin
               pos_in = '0;
               if (state_ff == S_INIT) state_in = S_IDLE;
               else begin
                  live_in = '0; rst_in = ST_CLEARED; rslot_in = '0; state_in = S_OUT;
               end
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               mode_in = req_mode; sel_in = req_slot_sel; len_in = len_c;
               lo_in = req_key_lo & lo_mask; hi_in = req_key_hi & hi_mask;
               acc_in = '0; bi_in = '0; pos_in = '0;
               rocc_in = 1'b0; rlo_in = '0; rhi_in = '0; rlen_in = '0;
               case (req_mode)
                  MODE_READ:  state_in = S_RDA;
                  MODE_CLEAR: state_in = S_CLEAR;
                  default:    state_in = S_HASH;
               endcase
            end
         end
         S_HASH: begin
            // accumulate byte * position; one byte a cycle
            if (bi_ff == BW'(len_ff)) begin
               acc_in = HW'(acc_ff * 19);
               state_in = S_MOD;
            end else begin
               acc_in = acc_ff + HW'(byte_v) * HW'(bi_ff + 1'b1);
               bi_in = bi_ff + 1'b1;
            end
         end
         S_MOD: begin
            quo_in = prod[RSH +: HW];
            state_in = S_REM;
         end
         S_REM: begin
            // keep the home slot in acc for a second probe pass
            acc_in = hrem;
            pos_in = SW'(hrem);
            step_in = SW'(24 % TABLE_SLOTS);
            j_in = '0; pass_in = 1'b0;
            state_in = S_ADDR;
         end
         S_ADDR: begin
            rd_en = 1'b1;
            state_in = S_CHECK;
         end
         S_CHECK: begin
            if (!pass_ff && hit) begin
               rslot_in = 7'(pos_ff);
               if (mode_ff == MODE_ADD) begin
                  rst_in = ST_PRESENT; state_in = S_OUT;
               end else begin
                  st_we = 1'b1; st_wdata = SLOT_DEAD;
                  if (live_ff != '0) live_in = live_ff - 1'b1;
                  rst_in = ST_DELETED; state_in = S_OUT;
               end
            end else if (pass_ff && stat_q != SLOT_LIVE) begin
               state_in = S_WRITE;
            end else if (j_ff == JW'(PROBE_LIMIT - 1)) begin
               if (!pass_ff && mode_ff == MODE_ADD) begin
                  pass_in = 1'b1; j_in = '0; pos_in = SW'(acc_ff);
                  step_in = SW'(24 % TABLE_SLOTS); state_in = S_ADDR;
               end else begin
                  rslot_in = '0;
                  rst_in = pass_ff ? ST_FULL : ST_MISSING;
                  state_in = S_OUT;
               end
            end else begin
               j_in = j_ff + 1'b1;
               pos_in = (wrap_sum >= (SW+1)'(TABLE_SLOTS)) ?
                        SW'(wrap_sum - (SW+1)'(TABLE_SLOTS)) : SW'(wrap_sum);
               step_in = (step_sum >= (SW+1)'(TABLE_SLOTS)) ?
                         SW'(step_sum - (SW+1)'(TABLE_SLOTS)) : SW'(step_sum);
               state_in = S_ADDR;
            end
         end
         S_WRITE: begin
            st_we = 1'b1; st_wdata = SLOT_LIVE; key_we = 1'b1;
            live_in = live_ff + 1'b1;
            rst_in = ST_INSERTED; rslot_in = 7'(pos_ff);
            state_in = S_OUT;
         end
         S_RDA: begin
            rd_addr = SW'(sel_ff);
            rd_en = (AW'(sel_ff) < AW'(TABLE_SLOTS));
            state_in = S_RDB;
         end
         S_RDB: begin
            rst_in = ST_READ; rslot_in = sel_ff;
            if ((AW'(sel_ff) < AW'(TABLE_SLOTS)) && stat_q == SLOT_LIVE) begin
               rocc_in = 1'b1; rlo_in = klo_q; rhi_in = khi_q; rlen_in = kln_q;
            end
            state_in = S_OUT;
         end
         S_OUT: begin
            // hold here while the previous result still waits
            if (!rv_ff || !rsp_stall) begin
               out_load = 1'b1;
               rv_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT; pos_ff <= '0; live_ff <= '0; rv_ff <= 1'b0;
      end else begin
         state_ff <= state_in; pos_ff <= pos_in; live_ff <= live_in; rv_ff <= rv_in;
      end
      mode_ff <= mode_in; lo_ff <= lo_in; hi_ff <= hi_in; len_ff <= len_in;
      sel_ff <= sel_in; acc_ff <= acc_in; quo_ff <= quo_in; bi_ff <= bi_in;
      step_ff <= step_in;
      j_ff <= j_in; pass_ff <= pass_in; rst_ff <= rst_in; rslot_ff <= rslot_in;
      rocc_ff <= rocc_in; rlo_ff <= rlo_in; rhi_ff <= rhi_in; rlen_ff <= rlen_in;
      if (out_load) begin
         out_status_ff <= rst_ff; out_slot_ff <= rslot_ff; out_occ_ff <= rocc_ff;
         out_lo_ff <= rlo_ff; out_hi_ff <= rhi_ff; out_len_ff <= rlen_ff;
         out_live_ff <= live_ff;
      end
   end

   assign rsp_valid = rv_ff;
   assign rsp_status = out_status_ff;
   assign rsp_slot = out_slot_ff;
   assign rsp_occupied = out_occ_ff;
   assign rsp_out_key_lo = out_lo_ff;
   assign rsp_out_key_hi = out_hi_ff;
   assign rsp_out_key_len = out_len_ff;
   assign rsp_live_count = out_live_ff;

`ifndef SYNTHESIS
   a_live_range: assert property (@(posedge clock) disable iff (reset)
      live_ff <= 7'(TABLE_SLOTS)) else $error("live count above table size");
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> req_stall) else $error("request taken while busy");
   a_result_holds: assert property (@(posedge clock) disable iff (reset)
      (rv_ff && rsp_stall) |=> (rv_ff && $stable(out_status_ff) && $stable(out_slot_ff)
                                && $stable(out_live_ff)))
      else $error("stalled result changed");
   a_probe_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ADDR) |-> (AW'(pos_ff) < AW'(TABLE_SLOTS)))
      else $error("probe slot out of range");
`endif
endmodule

[dv/open_address_hash_table_test.sv]
// Self-checking testbench for open_address_hash_table: random and directed table ops,
// an in-bench table predictor, and random valid/stall idling on both channels.
// Depends on oaht_pkg and the open_address_hash_table RTL.
module open_address_hash_table_test
   import oaht_pkg::*;
;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int Slots      = TableSlotsDef;
   localparam int Probes     = ProbeLimitDef;
   localparam int KeyBytes   = KeyBytesDef;
   localparam int IdleLimit  = 6000;
   localparam int HoldCycles = 400;

   typedef struct {
      logic [1:0]  mode;
      logic [63:0] key_lo;
      logic [55:0] key_hi;
      logic [3:0]  key_len;
      logic [6:0]  slot_sel;
      bit          drain_first;
   } table_op_type;

   typedef struct {
      logic [2:0]  status;
      logic [6:0]  slot;
      logic        occupied;
      logic [63:0] key_lo;
      logic [55:0] key_hi;
      logic [3:0]  key_len;
      logic [6:0]  live_count;
   } table_result_type;

   typedef struct {
      logic [63:0] lo;
      logic [55:0] hi;
      logic [3:0]  len;
   } key_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_mode = MODE_READ;
   logic [63:0] req_key_lo = '0;
   logic [55:0] req_key_hi = '0;
   logic [3:0]  req_key_len = '0;
   logic [6:0]  req_slot_sel = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [2:0]  rsp_status;
   logic [6:0]  rsp_slot;
   logic        rsp_occupied;
   logic [63:0] rsp_out_key_lo;
   logic [55:0] rsp_out_key_hi;
   logic [3:0]  rsp_out_key_len;
   logic [6:0]  rsp_live_count;

   open_address_hash_table uut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   table_op_type     queued_ops[$];
   table_result_type awaited_results[$];
   key_type          key_pool[48];
   int               ops_accepted = 0;
   int               results_seen = 0;
   int               mismatches = 0;
   int               idle_cycles = 0;

   // shadow table
   logic [1:0]  shadow_state[Slots];
   logic [63:0] shadow_lo[Slots];
   logic [55:0] shadow_hi[Slots];
   logic [3:0]  shadow_len[Slots];
   int unsigned shadow_live = 0;

   function automatic void append_op(table_op_type op);
      queued_ops.insert(queued_ops.size(), op);
   endfunction

   function automatic int unsigned home_slot(logic [63:0] lo, logic [55:0] hi, int unsigned n);
      int unsigned total;
      logic [7:0]  b;
      total = 0;
      for (int i = 0; i < n; i++) begin
         b = (i < 8) ? lo[8*i +: 8] : hi[8*(i-8) +: 8];
         total += b * (i + 1);
      end
      return (total * 19) % Slots;
   endfunction

   function automatic int locate_live(int unsigned h, logic [63:0] lo, logic [55:0] hi,
                                      logic [3:0] n);
      int unsigned s;
      for (int j = 0; j < Probes; j++) begin
         s = (h + j * j + 23 * j) % Slots;
         if (shadow_state[s] == SLOT_LIVE && shadow_len[s] == n && shadow_lo[s] == lo &&
             shadow_hi[s] == hi)
            return s;
      end
      return -1;
   endfunction

   function automatic table_result_type apply_table_op(table_op_type op);
      table_result_type r;
      int unsigned      n, h, s;
      logic [63:0]      lo;
      logic [55:0]      hi;
      int               f;
      r = '{ST_INSERTED, 7'd0, 1'b0, 64'd0, 56'd0, 4'd0, 7'd0};
      n = (op.key_len > KeyBytes) ? KeyBytes : op.key_len;
      lo = '0;
      hi = '0;
      for (int i = 0; i < n; i++) begin
         if (i < 8) lo[8*i +: 8] = op.key_lo[8*i +: 8];
         else hi[8*(i-8) +: 8] = op.key_hi[8*(i-8) +: 8];
      end
      h = home_slot(lo, hi, n);
      f = locate_live(h, lo, hi, 4'(n));
      case (op.mode)
         MODE_ADD: begin
            if (f >= 0) begin
               r.status = ST_PRESENT;
               r.slot = 7'(f);
            end else begin
               r.status = ST_FULL;
               for (int j = 0; j < Probes; j++) begin
                  s = (h + j * j + 23 * j) % Slots;
                  if (shadow_state[s] != SLOT_LIVE) begin
                     shadow_state[s] = SLOT_LIVE;
                     shadow_lo[s] = lo;
                     shadow_hi[s] = hi;
                     shadow_len[s] = 4'(n);
                     shadow_live++;
                     r.status = ST_INSERTED;
                     r.slot = 7'(s);
                     break;
                  end
               end
            end
         end
         MODE_DEL: begin
            if (f >= 0) begin
               shadow_state[f] = SLOT_DEAD;
               if (shadow_live > 0) shadow_live--;
               r.status = ST_DELETED;
               r.slot = 7'(f);
            end else begin
               r.status = ST_MISSING;
            end
         end
         MODE_READ: begin
            r.status = ST_READ;
            r.slot = op.slot_sel;
            if (op.slot_sel < Slots && shadow_state[op.slot_sel] == SLOT_LIVE) begin
               r.occupied = 1'b1;
               r.key_lo = shadow_lo[op.slot_sel];
               r.key_hi = shadow_hi[op.slot_sel];
               r.key_len = shadow_len[op.slot_sel];
            end
         end
         default: begin
            for (int i = 0; i < Slots; i++) shadow_state[i] = SLOT_NEVER;
            shadow_live = 0;
            r.status = ST_CLEARED;
         end
      endcase
      r.live_count = 7'(shadow_live);
      return r;
   endfunction

   function automatic table_op_type keyed_op(logic [1:0] mode, key_type k);
      table_op_type op;
      op.mode = mode;
      op.key_lo = k.lo;
      op.key_hi = k.hi;
      op.key_len = k.len;
      op.slot_sel = 7'($urandom_range(0, 127));
      op.drain_first = 1'b0;
      return op;
   endfunction

   function automatic key_type random_key();
      key_type k;
      k.lo = {$urandom, $urandom};
      k.hi = 56'({$urandom, $urandom});
      k.len = 4'(($urandom_range(0, 3) == 0) ? $urandom_range(9, 15) :
                                               $urandom_range(0, 8));
      return k;
   endfunction

   function automatic table_op_type read_op(int sel);
      table_op_type op;
      op = keyed_op(MODE_READ, random_key());
      op.slot_sel = 7'(sel);
      return op;
   endfunction

   // Two-byte keys with equal weighted sum share a probe path; 21 of them overflow it.
   task automatic queue_collision_burst();
      int      total;
      key_type k;
      total = $urandom_range(40, 255);
      for (int b2 = 0; b2 <= Probes; b2++) begin
         k.lo = {$urandom, $urandom};
         k.hi = 56'({$urandom, $urandom});
         k.lo[7:0] = 8'(total - 2 * b2);
         k.lo[15:8] = 8'(b2);
         k.len = 4'd2;
         append_op(keyed_op(MODE_ADD, k));
         if (b2 == 7) key_pool[$urandom_range(0, 47)] = k;
      end
   endtask

   initial begin
      key_type      k;
      table_op_type op;
      int           pick;
      for (int i = 0; i < Slots; i++) shadow_state[i] = SLOT_NEVER;
      for (int i = 0; i < 48; i++) key_pool[i] = random_key();
      // directed part
      append_op(keyed_op(MODE_CLEAR, '{64'd0, 56'd0, 4'd0}));
      k = '{{$urandom, $urandom}, 56'({$urandom, $urandom}), 4'd0};
      append_op(keyed_op(MODE_ADD, k));
      append_op(keyed_op(MODE_ADD, k));
      append_op(read_op(0));
      k = '{'1, '1, 4'd15};
      append_op(keyed_op(MODE_ADD, k));
      append_op(keyed_op(MODE_ADD, '{64'd0, 56'd0, 4'd15}));
      append_op(read_op(home_slot(64'hFFFF_FFFF_FFFF_FFFF, 56'hFF_FFFF_FFFF_FFFF, 15)));
      append_op(read_op(127));
      append_op(read_op(101));
      append_op(read_op(100));
      append_op(keyed_op(MODE_DEL, k));
      append_op(keyed_op(MODE_DEL, k));
      append_op(read_op(home_slot(64'hFFFF_FFFF_FFFF_FFFF, 56'hFF_FFFF_FFFF_FFFF, 15)));
      append_op(keyed_op(MODE_DEL, '{64'd0, 56'd0, 4'd0}));
      append_op(keyed_op(MODE_DEL, '{64'd0, 56'd0, 4'd0}));
      append_op(keyed_op(MODE_ADD, '{64'd0, 56'd0, 4'd0}));
      append_op(keyed_op(MODE_CLEAR, k));
      append_op(read_op(0));
      // random part
      for (int n = 0; n < 1550; n++) begin
         if (n % 250 == 10) queue_collision_burst();
         pick = $urandom_range(0, 99);
         if ($urandom_range(0, 9) == 0) k = random_key();
         else k = key_pool[$urandom_range(0, 47)];
         // vary the ignored bytes beyond the key length
         for (int i = k.len; i < KeyBytes; i++) begin
            if (i < 8) k.lo[8*i +: 8] = 8'($urandom);
            else k.hi[8*(i-8) +: 8] = 8'($urandom);
         end
         if (pick < 42) op = keyed_op(MODE_ADD, k);
         else if (pick < 70) op = keyed_op(MODE_DEL, k);
         else if (pick < 97) op = read_op($urandom_range(0, 5) == 0 ?
                                          $urandom_range(0, 127) : $urandom_range(0, 100));
         else op = keyed_op(MODE_CLEAR, k);
         op.drain_first = (n == 900);
         append_op(op);
      end
   end

   // request driver
   always @(posedge clock) begin
      bit offer;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            awaited_results.insert(awaited_results.size(),
                                   apply_table_op(queued_ops.pop_front()));
            ops_accepted++;
         end
         if (!(req_valid && req_stall)) begin
            offer = queued_ops.size() > 0;
            if (offer && queued_ops[0].drain_first && awaited_results.size() > 0) offer = 0;
            if (offer && !(ops_accepted >= 500 && ops_accepted < 800) &&
                $urandom_range(0, 99) < 31)
               offer = 0;
            req_valid <= offer;
            if (offer) begin
               req_mode <= queued_ops[0].mode;
               req_key_lo <= queued_ops[0].key_lo;
               req_key_hi <= queued_ops[0].key_hi;
               req_key_len <= queued_ops[0].key_len;
               req_slot_sel <= queued_ops[0].slot_sel;
            end
         end
      end
   end

   // result monitor
   int hold_left = 0;
   bit hold_done = 0;
   always @(posedge clock) begin
      table_result_type want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            results_seen++;
            if (awaited_results.size() == 0) begin
               $error("unexpected result beat, status %0d", rsp_status);
               mismatches++;
            end else begin
               want = awaited_results.pop_front();
               if (rsp_status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_status);
                  mismatches++;
               end
               if (rsp_slot !== want.slot) begin
                  $error("slot: expected %0d, got %0d", want.slot, rsp_slot);
                  mismatches++;
               end
               if (rsp_occupied !== want.occupied) begin
                  $error("occupied: expected %0d, got %0d", want.occupied, rsp_occupied);
                  mismatches++;
               end
               if (rsp_out_key_lo !== want.key_lo) begin
                  $error("out_key_lo: expected %h, got %h", want.key_lo, rsp_out_key_lo);
                  mismatches++;
               end
               if (rsp_out_key_hi !== want.key_hi) begin
                  $error("out_key_hi: expected %h, got %h", want.key_hi, rsp_out_key_hi);
                  mismatches++;
               end
               if (rsp_out_key_len !== want.key_len) begin
                  $error("out_key_len: expected %0d, got %0d", want.key_len, rsp_out_key_len);
                  mismatches++;
               end
               if (rsp_live_count !== want.live_count) begin
                  $error("live_count: expected %0d, got %0d", want.live_count,
                         rsp_live_count);
                  mismatches++;
               end
            end
         end
         // hold off once for a long stretch so the request side backs up
         if (!hold_done && results_seen == 300) begin
            hold_done <= 1;
            hold_left <= HoldCycles;
            rsp_stall <= 1'b1;
         end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            rsp_stall <= (hold_left > 1);
         end else begin
            rsp_stall <= !(results_seen >= 500 && results_seen < 800) &&
                         ($urandom_range(0, 99) < 31);
         end
      end
   end

   // watchdog on cycles without any accepted beat
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
         $display("[open_address_hash_table] ERROR");
         $finish;
      end
   end

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      while (queued_ops.size() > 0 || req_valid || awaited_results.size() > 0)
         @(posedge clock);
      repeat (300) @(posedge clock);
      if (mismatches == 0 && awaited_results.size() == 0)
         $display("[open_address_hash_table] OK");
      else
         $display("[open_address_hash_table] ERROR");
      $finish;
   end
endmodule
